/* hdl/pre_pkg.sv */
// ----------------------------------------------------------------------------
// pre_pkg
// Shared types and codes of the printable run extractor: item kinds,
// register indexes, controller states and the controller/datapath links.
// ----------------------------------------------------------------------------
package pre_pkg;

    // Result item kinds
    localparam logic [1:0] KIND_OFFSET = 2'd0;
    localparam logic [1:0] KIND_TEXT   = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    // Configuration register indexes
    localparam logic CFG_MIN_RUN     = 1'b0;
    localparam logic CFG_OFFSET_MODE = 1'b1;

    // Widths of the fixed fields
    localparam int CFG_W   = 6;
    localparam int VALUE_W = 48;

    // Printable range and tab
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OFFSET,
        ST_REPLAY,
        ST_CUR
    } state_t;

    // What goes into the output register
    typedef enum logic [2:0] {
        OUT_END,
        OUT_TEXT_IN,
        OUT_OFFSET,
        OUT_TEXT_HELD,
        OUT_TEXT_CUR
    } out_sel_t;

    typedef struct packed {
        logic     accept;
        logic     out_load;
        out_sel_t out_sel;
        logic     out_last;
        logic     rd_adv;
    } cmd_t;

    typedef struct packed {
        logic is_end;
        logic printable;
        logic in_run;
        logic complete;
        logic mode_nz;
        logic held_zero;
        logic rep_zero;
        logic rep_last;
        logic out_free;
    } stat_t;

endpackage

/* hdl/pre_ctrl.sv */
// ----------------------------------------------------------------------------
// pre_ctrl
// Controller of the printable run extractor: takes items and sequences the
// optional offset, held bytes and current byte when a run reaches its length.
// ----------------------------------------------------------------------------
module pre_ctrl
    import pre_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   acc;

    assign s_tready = (state_reg == ST_IDLE) && stat.out_free;
    assign acc      = s_tvalid && s_tready;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc && !stat.is_end && stat.printable && !stat.in_run && stat.complete)
                begin
                    if (stat.mode_nz)
                    begin
                        state_next = ST_OFFSET;
                    end
                    else if (stat.held_zero)
                    begin
                        state_next = ST_CUR;
                    end
                    else
                    begin
                        state_next = ST_REPLAY;
                    end
                end
            end
            ST_OFFSET:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.rep_zero ? ST_CUR : ST_REPLAY;
                end
            end
            ST_REPLAY:
            begin
                if (stat.out_free && stat.rep_last)
                begin
                    state_next = ST_CUR;
                end
            end
            ST_CUR:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd          = '0;
        cmd.out_sel  = OUT_END;
        cmd.accept   = acc;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    if (stat.is_end || !stat.printable)
                    begin
                        cmd.out_load = stat.in_run;
                        cmd.out_sel  = OUT_END;
                        cmd.out_last = 1'b1;
                    end
                    else if (stat.in_run)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_TEXT_IN;
                        cmd.out_last = 1'b1;
                    end
                end
            end
            ST_OFFSET:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_sel  = OUT_OFFSET;
            end
            ST_REPLAY:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_sel  = OUT_TEXT_HELD;
                cmd.rd_adv   = stat.out_free;
            end
            ST_CUR:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_sel  = OUT_TEXT_CUR;
                cmd.out_last = 1'b1;
            end
            default:
            begin
                cmd.out_load = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/pre_dp.sv */
// ----------------------------------------------------------------------------
// pre_dp
// Datapath of the printable run extractor: configuration, held byte memory,
// run state, byte position and the output register.
// ----------------------------------------------------------------------------
module pre_dp
    import pre_pkg::*;
#(
    parameter int MAX_RUN      = 32,
    parameter int OFFSET_WIDTH = 48
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_addr,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic [7:0]         in_byte,
    input  logic               in_end,
    input  cmd_t               cmd,
    output stat_t              stat,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic [VALUE_W-1:0] m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);

    localparam int AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

    logic [CFG_W-1:0]        min_len_reg;
    logic [1:0]              mode_reg;
    logic [AW-1:0]           held_cnt_reg;
    logic                    in_run_reg;
    logic [OFFSET_WIDTH-1:0] pos_reg;
    logic [7:0]              mem [MAX_RUN];
    logic [AW-1:0]           rd_ptr_reg;
    logic [AW-1:0]           rd_ptr_next;
    logic [7:0]              rd_data_reg;
    logic [AW-1:0]           rep_cnt_reg;
    logic [7:0]              cur_reg;
    logic [VALUE_W-1:0]      start_reg;
    logic                    out_valid_reg;
    logic [1:0]              out_kind_reg;
    logic [VALUE_W-1:0]      out_value_reg;
    logic                    out_last_reg;

    logic [CFG_W-1:0]        eff_len;
    logic                    printable;
    logic                    complete;
    logic                    store;
    logic                    finish;
    logic [OFFSET_WIDTH-1:0] start_val;

    // Clamp the run length to 1..MAX_RUN
    always_comb
    begin
        if (min_len_reg == '0)
        begin
            eff_len = CFG_W'(1);
        end
        else if (min_len_reg > CFG_W'(MAX_RUN))
        begin
            eff_len = CFG_W'(MAX_RUN);
        end
        else
        begin
            eff_len = min_len_reg;
        end
    end

    assign printable = ((in_byte >= CHAR_SPACE) && (in_byte <= CHAR_TILDE))
                       || (in_byte == CHAR_TAB);
    assign complete  = ((CFG_W + 1)'(held_cnt_reg) + (CFG_W + 1)'(1))
                       >= (CFG_W + 1)'(eff_len);
    assign finish    = cmd.accept && !in_end && printable && !in_run_reg && complete;
    assign store     = cmd.accept && !in_end && printable && !in_run_reg && !complete;

    // Offset of the first byte of the run, floored at zero
    assign start_val = (pos_reg >= OFFSET_WIDTH'(held_cnt_reg))
                       ? pos_reg - OFFSET_WIDTH'(held_cnt_reg) : '0;

    // Status to the controller
    always_comb
    begin
        stat.is_end    = in_end;
        stat.printable = printable;
        stat.in_run    = in_run_reg;
        stat.complete  = complete;
        stat.mode_nz   = (mode_reg != 2'd0);
        stat.held_zero = (held_cnt_reg == '0);
        stat.rep_zero  = (rep_cnt_reg == '0);
        stat.rep_last  = ((AW + 1)'(rd_ptr_reg) + (AW + 1)'(1)) == (AW + 1)'(rep_cnt_reg);
        stat.out_free  = !out_valid_reg || m_tready;
    end

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= CFG_W'(4);
            mode_reg    <= 2'd0;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CFG_MIN_RUN)
            begin
                min_len_reg <= cfg_wdata;
            end
            else if (cfg_addr == CFG_OFFSET_MODE)
            begin
                mode_reg <= cfg_wdata[1:0];
            end
        end
    end

    // Track run state and byte position on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg <= '0;
            in_run_reg   <= 1'b0;
            pos_reg      <= '0;
            rep_cnt_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            if (in_end)
            begin
                held_cnt_reg <= '0;
                in_run_reg   <= 1'b0;
                pos_reg      <= '0;
            end
            else
            begin
                if (pos_reg != '1)
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
                if (!printable)
                begin
                    held_cnt_reg <= '0;
                    in_run_reg   <= 1'b0;
                end
                else if (finish)
                begin
                    rep_cnt_reg  <= held_cnt_reg;
                    held_cnt_reg <= '0;
                    in_run_reg   <= 1'b1;
                end
                else if (store)
                begin
                    held_cnt_reg <= held_cnt_reg + 1'b1;
                end
            end
        end
    end

    // Capture the completing byte and the run's start offset
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            cur_reg   <= in_byte;
            start_reg <= VALUE_W'(start_val);
        end
    end

    // Advance the replay pointer
    always_comb
    begin
        if (cmd.accept)
        begin
            rd_ptr_next = '0;
        end
        else if (cmd.rd_adv)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        else
        begin
            rd_ptr_next = rd_ptr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Held byte memory, registered read
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            mem[held_cnt_reg] <= in_byte;
        end
        rd_data_reg <= mem[rd_ptr_next];
    end

    // Output register: load on command, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_last_reg <= cmd.out_last;
            case (cmd.out_sel)
                OUT_END:
                begin
                    out_kind_reg  <= KIND_END;
                    out_value_reg <= '0;
                end
                OUT_TEXT_IN:
                begin
                    out_kind_reg  <= KIND_TEXT;
                    out_value_reg <= VALUE_W'(in_byte);
                end
                OUT_OFFSET:
                begin
                    out_kind_reg  <= KIND_OFFSET;
                    out_value_reg <= start_reg;
                end
                OUT_TEXT_HELD:
                begin
                    out_kind_reg  <= KIND_TEXT;
                    out_value_reg <= VALUE_W'(rd_data_reg);
                end
                OUT_TEXT_CUR:
                begin
                    out_kind_reg  <= KIND_TEXT;
                    out_value_reg <= VALUE_W'(cur_reg);
                end
                default:
                begin
                    out_kind_reg  <= KIND_END;
                    out_value_reg <= '0;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* hdl/printable_run_extractor_core.sv */
// ----------------------------------------------------------------------------
// printable_run_extractor_core
// Finds runs of printable bytes in a byte stream and reports those that reach
// the programmed minimum length, with an optional binary start offset.
// ----------------------------------------------------------------------------
// A byte that does not complete a run leaves the block idle, so plain bytes,
// pass-through bytes, run ends and stream ends flow at one item per cycle
// while the output is being drained. After a completing byte, the offset item
// (when enabled), the held bytes (up to MAX_RUN-1) and that byte go out before
// the next item is taken. The single output register presents one result per
// cycle while drained, replaying the held bytes from the held byte memory
// through its one registered read port. The held byte memory needs no clearing
// after reset. The user writes configuration only while the block is idle;
// the block does not enforce it.
module printable_run_extractor_core
    import pre_pkg::*;
#(
    parameter int MAX_RUN      = 32,
    parameter int OFFSET_WIDTH = 48
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_we,
    input  logic               cfg_addr,
    input  logic [CFG_W-1:0]   cfg_wdata,
    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,   // stream_end
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [VALUE_W-1:0] m_tdata,   // [47:0] item_value
    output logic [1:0]         m_tuser,   // [1:0] item_kind
    output logic               m_tlast    // last_of_run
);

    cmd_t  cmd;
    stat_t stat;

    // Sequence items and results
    pre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold run state, held bytes and the output register
    pre_dp #(
        .MAX_RUN      (MAX_RUN),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_byte   (s_tdata),
        .in_end    (s_tlast),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
